// ----- hw/rtl/cigar_md_mismatch_counter_top_defines.svh -----
// Assertion macros for the top-level RTL file, the one file that carries checks.
`ifndef CIGAR_MD_MISMATCH_COUNTER_TOP_DEFINES_SVH
`define CIGAR_MD_MISMATCH_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define CMMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmmc same-cycle check failed");
// Next-cycle implication.
`define CMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmmc next-cycle check failed");
`else
`define CMMC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/cmmc_pkg.sv -----
`default_nettype none

package cmmc_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    localparam logic [1:0] MODE_CIGAR  = 2'd0;
    localparam logic [1:0] MODE_MD     = 2'd1;
    localparam logic [1:0] MODE_END    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_QUEUE_FULL  = 2'd1;
    localparam logic [1:0] ERR_NO_DELETION = 2'd2;

    typedef enum logic [2:0] {
        OP_CIG_DIGIT,
        OP_CIG_DEL,
        OP_CIG_INS,
        OP_CIG_OTHER,
        OP_MD_CARET,
        OP_MD_DIGIT,
        OP_MD_MISMATCH,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

`default_nettype wire

// ----- hw/rtl/cigar_md_mismatch_counter_top.sv -----
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         ch[7:0]                                     mode[1:0]
// m_axis    out        mismatch_count[15:0], indel_total[31:16],   -
//                      error_code[33:32], zero pad [39:34]
//
// One request per cycle sustained while m_axis keeps up; a four-entry queue sits
// between the classifier and the counting unit, whose single update per cycle sets the rate.
// An end request is written into the queue, and its result is then held in the counting unit's output register.
// Reset is synchronous and clears all counters; the deletion store needs no clear.
// s_axis_tready falls only when the queue is full; the counting unit waits only
// when an end request meets a result that m_axis has not yet taken.
`default_nettype none
`include "cigar_md_mismatch_counter_top_defines.svh"

module cigar_md_mismatch_counter_top #(
    parameter int unsigned MAX_DELETIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // mismatch_count, indel_total, error_code
);

    cmmc_pkg::t_push        push;
    cmmc_pkg::t_fifo_status fifo_status;
    cmmc_pkg::t_item        fifo_item;
    logic                   fifo_valid;
    logic                   pop;
    logic [15:0]            res_mm;
    logic [15:0]            res_indel;
    logic [1:0]             res_err;

    cmmc_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_mode   (s_axis_tuser),
        .i_ch     (s_axis_tdata),
        .i_status (fifo_status),
        .o_ready  (s_axis_tready),
        .o_push   (push)
    );

    cmmc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (fifo_status),
        .i_pop    (pop),
        .o_valid  (fifo_valid),
        .o_item   (fifo_item)
    );

    cmmc_back #(
        .MAX_DELETIONS (MAX_DELETIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fifo_valid),
        .i_item     (fifo_item),
        .o_pop      (pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_mismatch (res_mm),
        .o_indel    (res_indel),
        .o_err      (res_err)
    );

    assign m_axis_tdata = {6'b0, res_err, res_indel, res_mm};

    `CMMC_ASSERT_NOW(a_fifo_flags, i_clk, i_rst_n, fifo_status.full, !fifo_status.empty)
    `CMMC_ASSERT_NOW(a_unused_mode_dropped, i_clk, i_rst_n,
                     s_axis_tuser == cmmc_pkg::MODE_UNUSED, !push.valid)
    `CMMC_ASSERT_NEXT(a_result_from_end, i_clk, i_rst_n,
                      pop && (fifo_item.op == cmmc_pkg::OP_END), m_axis_tvalid)

endmodule

`default_nettype wire

// ----- hw/rtl/cmmc_ram.sv -----
`default_nettype none

module cmmc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cmmc_front.sv -----
`default_nettype none

module cmmc_front (
    input  wire logic                  i_valid,
    input  wire logic [1:0]            i_mode,
    input  wire logic [7:0]            i_ch,
    input  wire cmmc_pkg::t_fifo_status i_status,
    output logic                       o_ready,
    output cmmc_pkg::t_push            o_push
);

    logic is_digit;

    assign is_digit = (i_ch >= cmmc_pkg::CH_ZERO) && (i_ch <= cmmc_pkg::CH_NINE);
    assign o_ready  = !i_status.full;

    always_comb begin
        o_push.valid      = 1'b0;
        o_push.item.op    = cmmc_pkg::OP_END;
        // ASCII digits sit at 0x30..0x39, so the low nibble is the value.
        o_push.item.digit = i_ch[3:0];
        unique case (i_mode)
            cmmc_pkg::MODE_CIGAR: begin
                o_push.valid = i_valid && o_ready;
                if (is_digit) begin
                    o_push.item.op = cmmc_pkg::OP_CIG_DIGIT;
                end else if (i_ch == cmmc_pkg::CH_D) begin
                    o_push.item.op = cmmc_pkg::OP_CIG_DEL;
                end else if (i_ch == cmmc_pkg::CH_I) begin
                    o_push.item.op = cmmc_pkg::OP_CIG_INS;
                end else begin
                    o_push.item.op = cmmc_pkg::OP_CIG_OTHER;
                end
            end
            cmmc_pkg::MODE_MD: begin
                o_push.valid = i_valid && o_ready;
                if (i_ch == cmmc_pkg::CH_CARET) begin
                    o_push.item.op = cmmc_pkg::OP_MD_CARET;
                end else if (is_digit) begin
                    o_push.item.op = cmmc_pkg::OP_MD_DIGIT;
                end else begin
                    o_push.item.op = cmmc_pkg::OP_MD_MISMATCH;
                end
            end
            cmmc_pkg::MODE_END: begin
                o_push.valid   = i_valid && o_ready;
                o_push.item.op = cmmc_pkg::OP_END;
            end
            // The unused mode code is taken and dropped.
            default: o_push.valid = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cmmc_fifo.sv -----
`default_nettype none

module cmmc_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cmmc_pkg::t_push        i_push,
    output cmmc_pkg::t_fifo_status      o_status,
    input  wire logic                   i_pop,
    output logic                        o_valid,
    output cmmc_pkg::t_item             o_item
);

    cmmc_pkg::t_item                      r_mem [cmmc_pkg::FIFO_DEPTH];
    logic [cmmc_pkg::FIFO_PTR_W-1:0]      r_wr_ptr;
    logic [cmmc_pkg::FIFO_PTR_W-1:0]      r_rd_ptr;
    logic [cmmc_pkg::FIFO_CNT_W-1:0]      r_cnt;
    logic                                 do_push;
    logic                                 do_pop;

    assign o_status.full  = (r_cnt == cmmc_pkg::FIFO_CNT_W'(cmmc_pkg::FIFO_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_valid        = !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cmmc_back.sv -----
`default_nettype none

module cmmc_back #(
    parameter int unsigned MAX_DELETIONS = 16,
    localparam int unsigned AW = (MAX_DELETIONS > 1) ? $clog2(MAX_DELETIONS) : 1,
    localparam int unsigned CW = $clog2(MAX_DELETIONS + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire cmmc_pkg::t_item             i_item,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [cmmc_pkg::CNT_W-1:0]       o_mismatch,
    output logic [cmmc_pkg::CNT_W-1:0]       o_indel,
    output logic [1:0]                       o_err
);

    localparam int unsigned W = cmmc_pkg::CNT_W;

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_indel, n_indel;
    logic [W-1:0]  r_mm, n_mm;
    logic [W-1:0]  r_skip, n_skip;
    logic [CW-1:0] r_wr, n_wr;
    logic [CW-1:0] r_rd, n_rd;
    logic [1:0]    r_err, n_err;
    logic          r_byp_valid;
    logic [W-1:0]  r_byp_data;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_out_mm, n_out_mm;
    logic [W-1:0]  r_out_indel, n_out_indel;
    logic [1:0]    r_out_err, n_out_err;

    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;
    logic [W-1:0]  head;
    logic [W+3:0]  acc_ext;
    logic [W+3:0]  acc_next;
    logic [W:0]    indel_add;
    logic [W:0]    mm_add;

    assign out_free  = !r_out_valid || i_tready;
    assign o_pop     = i_valid && ((i_item.op != cmmc_pkg::OP_END) || out_free);
    assign ram_waddr = r_wr[AW-1:0];
    assign ram_raddr = n_rd[AW-1:0];
    // A same-cycle write to the entry being read comes from the bypass register.
    assign head      = r_byp_valid ? r_byp_data : ram_rdata;
    assign acc_ext   = {4'b0, r_acc};
    assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + {{W{1'b0}}, i_item.digit};
    assign indel_add = {1'b0, r_indel} + {1'b0, r_acc};
    assign mm_add    = {1'b0, r_mm} + {{W{1'b0}}, 1'b1};

    assign o_tvalid   = r_out_valid;
    assign o_mismatch = r_out_mm;
    assign o_indel    = r_out_indel;
    assign o_err      = r_out_err;

    cmmc_ram #(
        .WIDTH (W),
        .DEPTH (MAX_DELETIONS)
    ) u_del_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_acc),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_acc       = r_acc;
        n_indel     = r_indel;
        n_mm        = r_mm;
        n_skip      = r_skip;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_err       = r_err;
        ram_we      = 1'b0;
        n_out_valid = r_out_valid && !i_tready;
        n_out_mm    = r_out_mm;
        n_out_indel = r_out_indel;
        n_out_err   = r_out_err;
        if (o_pop) begin
            case (i_item.op) inside
                cmmc_pkg::OP_CIG_DIGIT: begin
                    n_acc = (acc_next > {4'b0, cmmc_pkg::CNT_SAT}) ?
                            cmmc_pkg::CNT_SAT : acc_next[W-1:0];
                end
                cmmc_pkg::OP_CIG_DEL, cmmc_pkg::OP_CIG_INS: begin
                    n_indel = indel_add[W] ? cmmc_pkg::CNT_SAT : indel_add[W-1:0];
                    n_acc   = '0;
                    if (i_item.op == cmmc_pkg::OP_CIG_DEL) begin
                        if (r_wr < CW'(MAX_DELETIONS)) begin
                            ram_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                        end else if (r_err == cmmc_pkg::ERR_NONE) begin
                            n_err = cmmc_pkg::ERR_QUEUE_FULL;
                        end
                    end
                end
                cmmc_pkg::OP_CIG_OTHER: begin
                    n_acc = '0;
                end
                cmmc_pkg::OP_MD_CARET, cmmc_pkg::OP_MD_DIGIT,
                cmmc_pkg::OP_MD_MISMATCH: begin
                    // Inside a deletion run every MD character is consumed silently.
                    if (r_skip != '0) begin
                        n_skip = r_skip - 1'b1;
                    end else if (i_item.op == cmmc_pkg::OP_MD_CARET) begin
                        if (r_rd < r_wr) begin
                            n_skip = head;
                            n_rd   = r_rd + 1'b1;
                        end else if (r_err == cmmc_pkg::ERR_NONE) begin
                            n_err = cmmc_pkg::ERR_NO_DELETION;
                        end
                    end else if (i_item.op == cmmc_pkg::OP_MD_MISMATCH) begin
                        n_mm = mm_add[W] ? cmmc_pkg::CNT_SAT : mm_add[W-1:0];
                    end
                end
                cmmc_pkg::OP_END: begin
                    n_out_valid = 1'b1;
                    n_out_mm    = r_mm;
                    n_out_indel = r_indel;
                    n_out_err   = r_err;
                    n_acc       = '0;
                    n_indel     = '0;
                    n_mm        = '0;
                    n_skip      = '0;
                    n_wr        = '0;
                    n_rd        = '0;
                    n_err       = cmmc_pkg::ERR_NONE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data  <= r_acc;
        r_out_mm    <= n_out_mm;
        r_out_indel <= n_out_indel;
        r_out_err   <= n_out_err;
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_indel     <= '0;
            r_mm        <= '0;
            r_skip      <= '0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_err       <= cmmc_pkg::ERR_NONE;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_indel     <= n_indel;
            r_mm        <= n_mm;
            r_skip      <= n_skip;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_err       <= n_err;
            r_byp_valid <= ram_we && (ram_waddr == ram_raddr);
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- bench/cigar_md_mismatch_counter_top_test.sv -----
module cigar_md_mismatch_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEL_DEPTH      = 16;
    localparam int unsigned RANDOM_ITEMS   = 750;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 16;

    // Packed so that the lowest field sits in the lowest bits of m_axis_tdata.
    typedef struct packed {
        logic [1:0]  error_code;
        logic [15:0] indel_total;
        logic [15:0] mismatch_count;
    } t_tally;

    class t_scoreboard;
        logic [15:0]  len_accum;
        logic [15:0]  indel_sum;
        logic [15:0]  mismatch_sum;
        logic [15:0]  skip_left;
        logic [15:0]  del_lengths [DEL_DEPTH];
        int unsigned  del_written;
        int unsigned  del_read;
        logic [1:0]   err_held;
        t_tally       pending_tallies [$];
        int unsigned  fail_count;

        function new();
            clear();
            fail_count = 0;
        endfunction

        function void clear();
            len_accum    = '0;
            indel_sum    = '0;
            mismatch_sum = '0;
            skip_left    = '0;
            del_written  = 0;
            del_read     = 0;
            err_held     = cmmc_pkg::ERR_NONE;
        endfunction

        function logic [15:0] sat_add(logic [15:0] a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > cmmc_pkg::CNT_SAT) ? cmmc_pkg::CNT_SAT : s[15:0];
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= cmmc_pkg::CH_ZERO && c <= cmmc_pkg::CH_NINE;
        endfunction

        function void hold_error(logic [1:0] code);
            if (err_held == cmmc_pkg::ERR_NONE) begin
                err_held = code;
            end
        endfunction

        function void take_cigar_char(logic [7:0] c);
            int unsigned v;
            if (is_digit(c)) begin
                v = len_accum * 10 + (c - cmmc_pkg::CH_ZERO);
                len_accum = (v > cmmc_pkg::CNT_SAT) ? cmmc_pkg::CNT_SAT : v[15:0];
                return;
            end
            if (c == cmmc_pkg::CH_D || c == cmmc_pkg::CH_I) begin
                indel_sum = sat_add(indel_sum, len_accum);
                if (c == cmmc_pkg::CH_D) begin
                    if (del_written < DEL_DEPTH) begin
                        del_lengths[del_written] = len_accum;
                        del_written++;
                    end else begin
                        hold_error(cmmc_pkg::ERR_QUEUE_FULL);
                    end
                end
            end
            len_accum = '0;
        endfunction

        function void take_md_char(logic [7:0] c);
            if (skip_left != 0) begin
                skip_left--;
                return;
            end
            if (c == cmmc_pkg::CH_CARET) begin
                if (del_read < del_written) begin
                    skip_left = del_lengths[del_read];
                    del_read++;
                end else begin
                    hold_error(cmmc_pkg::ERR_NO_DELETION);
                end
                return;
            end
            if (!is_digit(c)) begin
                mismatch_sum = sat_add(mismatch_sum, 1);
            end
        endfunction

        function void note_request(logic [1:0] mode, logic [7:0] c);
            t_tally t;
            case (mode)
                cmmc_pkg::MODE_CIGAR: take_cigar_char(c);
                cmmc_pkg::MODE_MD:    take_md_char(c);
                cmmc_pkg::MODE_END: begin
                    t.mismatch_count = mismatch_sum;
                    t.indel_total    = indel_sum;
                    t.error_code     = err_held;
                    pending_tallies  = {pending_tallies, t};
                    clear();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [39:0] data);
            t_tally got;
            t_tally exp_t;
            got = data[33:0];
            if (pending_tallies.size() == 0) begin
                $error("unexpected result: tdata %h", data);
                fail_count++;
                return;
            end
            exp_t = pending_tallies.pop_front();
            if (got.mismatch_count != exp_t.mismatch_count) begin
                $error("mismatch_count: expected %0d, actual %0d",
                       exp_t.mismatch_count, got.mismatch_count);
                fail_count++;
            end
            if (got.indel_total != exp_t.indel_total) begin
                $error("indel_total: expected %0d, actual %0d",
                       exp_t.indel_total, got.indel_total);
                fail_count++;
            end
            if (got.error_code != exp_t.error_code) begin
                $error("error_code: expected %0d, actual %0d",
                       exp_t.error_code, got.error_code);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return pending_tallies.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // ch[7:0]
    logic [1:0]  s_axis_tuser  = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // mismatch_count, indel_total, error_code

    t_scoreboard board = new();
    bit          src_idle  = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned item_count;
    int unsigned idle_cycles;

    cigar_md_mismatch_counter_top #(
        .MAX_DELETIONS(DEL_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Any cycle that moves a request or a result resets the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_char(input logic [1:0] mode, input logic [7:0] c);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(mode, c);
        item_count++;
    endtask

    task automatic push_decimal(input logic [1:0] mode, input int unsigned n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) begin
            push_char(mode, s[i]);
        end
    endtask

    function automatic logic [7:0] base_char();
        case ($urandom_range(0, 4))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            default: return "N";
        endcase
    endfunction

    // Mostly bases, but now and then anything at all, carets and digits included.
    function automatic logic [7:0] deleted_char();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : base_char();
    endfunction

    function automatic logic [7:0] noisy_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(cmmc_pkg::CH_ZERO, cmmc_pkg::CH_NINE));
            1: return cmmc_pkg::CH_D;
            2: return cmmc_pkg::CH_I;
            3: return cmmc_pkg::CH_CARET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A record whose MD string matches its CIGAR deletions; a broken one may add
    // a run of deletions that can overflow the queue, and adds stray MD characters.
    task automatic well_formed_record(input bit broken);
        int unsigned dels [$];
        int unsigned nops;
        int unsigned n;
        logic [7:0]  op;
        nops = $urandom_range(1, 6);
        repeat (nops) begin
            case ($urandom_range(0, 7))
                0, 1: op = cmmc_pkg::CH_D;
                2, 3: op = cmmc_pkg::CH_I;
                4: op = "M";
                5: op = "S";
                6: op = "=";
                default: op = "X";
            endcase
            if (op == cmmc_pkg::CH_D) begin
                n = $urandom_range(0, 6);
            end else if ($urandom_range(0, 15) == 0) begin
                n = $urandom_range(0, 99999);
            end else begin
                n = $urandom_range(1, 150);
            end
            if ($urandom_range(0, 7) == 0) begin
                n = 0;
            end else begin
                push_decimal(cmmc_pkg::MODE_CIGAR, n);
            end
            push_char(cmmc_pkg::MODE_CIGAR, op);
            if (op == cmmc_pkg::CH_D) begin
                dels = {dels, n};
            end
        end
        if (broken && $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(10, 20)) begin
                push_char(cmmc_pkg::MODE_CIGAR, "1");
                push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_D);
                dels = {dels, 32'd1};
            end
        end
        foreach (dels[k]) begin
            push_decimal(cmmc_pkg::MODE_MD, $urandom_range(0, 30));
            if ($urandom_range(0, 1) == 1) begin
                push_char(cmmc_pkg::MODE_MD, base_char());
            end
            push_char(cmmc_pkg::MODE_MD, cmmc_pkg::CH_CARET);
            repeat (dels[k]) push_char(cmmc_pkg::MODE_MD, deleted_char());
        end
        push_decimal(cmmc_pkg::MODE_MD, $urandom_range(0, 30));
        if ($urandom_range(0, 1) == 1) begin
            push_char(cmmc_pkg::MODE_MD, base_char());
            push_decimal(cmmc_pkg::MODE_MD, $urandom_range(0, 9));
        end
        if (broken) begin
            repeat ($urandom_range(1, 4)) push_char(cmmc_pkg::MODE_MD, noisy_char());
        end
        push_char(cmmc_pkg::MODE_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic noise_record();
        logic [1:0] mode;
        repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 9))
                0: mode = cmmc_pkg::MODE_UNUSED;
                1: mode = cmmc_pkg::MODE_END;
                2, 3, 4, 5: mode = cmmc_pkg::MODE_CIGAR;
                default: mode = cmmc_pkg::MODE_MD;
            endcase
            push_char(mode, noisy_char());
        end
        push_char(cmmc_pkg::MODE_END, 8'($urandom_range(0, 255)));
    endtask

    // Result side: random stalls, every result checked at its handshake.
    initial begin
        int unsigned gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = sink_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata);
        end
    end

    initial begin
        int unsigned pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-length and other operations, a caret with the queue drained,
        // skipped carets and digits, an ignored mode and a zero ch.
        push_char(cmmc_pkg::MODE_CIGAR, "3");
        push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_D);
        push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_I);
        push_char(cmmc_pkg::MODE_CIGAR, "2");
        push_char(cmmc_pkg::MODE_CIGAR, "M");
        push_char(cmmc_pkg::MODE_CIGAR, "2");
        push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_I);
        push_char(cmmc_pkg::MODE_MD, "1");
        push_char(cmmc_pkg::MODE_MD, "A");
        push_char(cmmc_pkg::MODE_MD, cmmc_pkg::CH_CARET);
        push_char(cmmc_pkg::MODE_MD, cmmc_pkg::CH_CARET);
        push_char(cmmc_pkg::MODE_MD, "7");
        push_char(cmmc_pkg::MODE_MD, "C");
        push_char(cmmc_pkg::MODE_MD, cmmc_pkg::CH_CARET);
        push_char(cmmc_pkg::MODE_UNUSED, "G");
        push_char(cmmc_pkg::MODE_MD, "G");
        push_char(cmmc_pkg::MODE_END, 8'h00);
        // A long decimal run and an indel total that both saturate, and both ch extremes.
        repeat (6) push_char(cmmc_pkg::MODE_CIGAR, "9");
        push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_I);
        push_char(cmmc_pkg::MODE_CIGAR, "1");
        push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_I);
        push_char(cmmc_pkg::MODE_CIGAR, 8'hFF);
        push_char(cmmc_pkg::MODE_MD, 8'h00);
        push_char(cmmc_pkg::MODE_END, 8'hFF);
        push_char(cmmc_pkg::MODE_END, 8'h5A);

        // Deletion queue overflow, followed by a caret that still finds a stored deletion.
        repeat (18) begin
            push_char(cmmc_pkg::MODE_CIGAR, "2");
            push_char(cmmc_pkg::MODE_CIGAR, cmmc_pkg::CH_D);
        end
        push_char(cmmc_pkg::MODE_MD, cmmc_pkg::CH_CARET);
        push_char(cmmc_pkg::MODE_MD, "A");
        push_char(cmmc_pkg::MODE_MD, "B");
        push_char(cmmc_pkg::MODE_MD, "C");
        push_char(cmmc_pkg::MODE_END, 8'h00);

        while (item_count < RANDOM_ITEMS) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                well_formed_record(1'b0);
            end else if (pick < 17) begin
                well_formed_record(1'b1);
            end else begin
                noise_record();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
